// ===== rtl/pip_pkg.sv =====
// Shared constants, types and codes for the point-in-polygon test core.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 24;
    localparam int VADDR_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W        = 7;
    localparam int SLOT_W       = 6;
    localparam int PT_IN_W      = 16;
    localparam int FRAC_W       = 8;
    localparam int PT_W         = PT_IN_W + FRAC_W;
    localparam int EXT_W        = (COORD_W > PT_W) ? COORD_W : PT_W;
    localparam int DIFF_W       = EXT_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VTX_W        = 2 * COORD_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // Control that goes with each word read from the vertex memory
    typedef struct packed {
        logic vld;
        logic first;
        logic clr;
    } t_edge_ctl;

endpackage

// ===== rtl/point_in_polygon_test_core.sv =====
// Top level: even-odd point-in-polygon test over a stored vertex list.
// Timing: a load item is written in the cycle it is accepted; a query over n corners
//   registers its result once the walk and edge pipeline are done and the slot is free.
// Throughput: one load per cycle while idle; no input is taken while a query is busy,
//   and the single vertex memory read port delivers one corner (one edge) per cycle.
// Reset: clears control, the result valid flag and vertex_count; corner storage
//   is not cleared and holds nothing defined until written.
module point_in_polygon_test_core
    import pip_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: vertex_count
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // input transactions
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [SLOT_W-1:0]         i_vertex_slot,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic signed [PT_IN_W-1:0] i_point_x,
    input  logic signed [PT_IN_W-1:0] i_point_y,
    // result transactions
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_inside_res
);

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [CNT_W-1:0]        r_rd_cnt, n_rd_cnt;
    logic signed [PT_W-1:0]  r_px, r_py;
    logic                    r_rd_vld, r_rd_first;
    logic                    r_out_vld, n_out_vld;
    logic                    r_out_inside, n_out_inside;

    logic                    in_acc, query_acc, load_en, rd_en;
    logic [CNT_W-1:0]        n_clamped, rd_idx;
    logic [VTX_W-1:0]        rd_data;
    logic                    edge_busy, parity;
    t_edge_ctl               edge_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign query_acc   = in_acc && (i_kind == KIND_QUERY);
    // drop loads aimed past the end of the store
    assign load_en     = in_acc && (i_kind == KIND_LOAD)
                         && (32'(i_vertex_slot) < MAX_VERTICES);

    // a count above the store depth is used as the full store
    assign n_clamped = (32'(r_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(r_count);

    // read order: the last corner first (j of edge zero), then 0 .. n-1
    assign rd_idx = (r_rd_cnt == '0) ? (r_n - CNT_W'(1)) : (r_rd_cnt - CNT_W'(1));
    assign rd_en  = (r_state == ST_WALK);

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_rd_cnt     = r_rd_cnt;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_inside = r_out_inside;
        unique case (r_state)
            ST_IDLE: begin
                if (query_acc) begin
                    n_n      = n_clamped;
                    n_rd_cnt = '0;
                    n_state  = (n_clamped == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK: begin
                // advance one corner per cycle; n + 1 reads in all
                n_rd_cnt = r_rd_cnt + CNT_W'(1);
                if (r_rd_cnt == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last edge to leave the pipeline and a free result slot
                if (!r_rd_vld && !edge_busy && (!r_out_vld || i_out_ready)) begin
                    n_out_vld    = 1'b1;
                    n_out_inside = parity;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_en;
            r_rd_first <= rd_en && (r_rd_cnt == '0);
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_rd_cnt     <= n_rd_cnt;
        r_out_inside <= n_out_inside;
        if (query_acc) begin
            // scale the integer point into the Q.8 vertex format
            r_px <= signed'({i_point_x, {FRAC_W{1'b0}}});
            r_py <= signed'({i_point_y, {FRAC_W{1'b0}}});
        end
    end

    pip_vtx_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_en),
        .i_wr_addr (VADDR_W'(i_vertex_slot)),
        .i_wr_data ({i_vertex_x, i_vertex_y}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_idx[VADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign edge_ctl.vld   = r_rd_vld;
    assign edge_ctl.first = r_rd_first;
    assign edge_ctl.clr   = query_acc;

    pip_edge_unit u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (edge_ctl),
        .i_vtx    (rd_data),
        .i_px     (r_px),
        .i_py     (r_py),
        .o_busy   (edge_busy),
        .o_parity (parity)
    );

    assign o_out_valid  = r_out_vld;
    assign o_inside_res = r_out_inside;

    // The edge pipeline is empty whenever a new transaction may enter.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!edge_busy && !r_rd_vld))
        else $error("edge pipeline busy while idle");

    // The read counter never passes the corner count.
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rd_cnt <= r_n))
        else $error("vertex read counter overran the corner count");

    // An empty polygon skips the walk.
    a_empty_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (query_acc && (n_clamped == '0)) |=> (r_state == ST_DRAIN))
        else $error("empty polygon query entered the walk");

endmodule

// ===== rtl/pip_vtx_mem.sv =====
// Vertex store: one write port, one read port with registered read data.
module pip_vtx_mem
    import pip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [VADDR_W-1:0] i_wr_addr,
    input  logic [VTX_W-1:0]   i_wr_data,
    input  logic               i_rd_en,
    input  logic [VADDR_W-1:0] i_rd_addr,
    output logic [VTX_W-1:0]   o_rd_data
);

    logic [VTX_W-1:0] r_mem [MAX_VERTICES];
    logic [VTX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pip_edge_unit.sv =====
// Edge pipeline: straddle check, cross products, compare and parity toggle.
module pip_edge_unit
    import pip_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_edge_ctl              i_ctl,
    input  logic [VTX_W-1:0]       i_vtx,
    input  logic signed [PT_W-1:0] i_px,
    input  logic signed [PT_W-1:0] i_py,
    output logic                   o_busy,
    output logic                   o_parity
);

    logic signed [COORD_W-1:0] xi, yi;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [DIFF_W-1:0]  xi_e, yi_e, xj_e, yj_e, px_e, py_e;
    logic                      straddle;

    // stage A
    logic                      r_a_vld, r_a_hit;
    logic signed [DIFF_W-1:0]  r_a_dx, r_a_dy, r_a_ax, r_a_by;
    // stage B
    logic                      r_b_vld, r_b_hit, r_b_dy_pos;
    logic signed [PROD_W-1:0]  r_b_lhs, r_b_rhs;
    logic                      left;
    logic                      r_parity;

    assign xi   = i_vtx[VTX_W-1:COORD_W];
    assign yi   = i_vtx[COORD_W-1:0];
    assign xi_e = DIFF_W'(xi);
    assign yi_e = DIFF_W'(yi);
    assign xj_e = DIFF_W'(r_prev_x);
    assign yj_e = DIFF_W'(r_prev_y);
    assign px_e = DIFF_W'(i_px);
    assign py_e = DIFF_W'(i_py);

    assign straddle = (yi_e > py_e) != (yj_e > py_e);

    // hold the previous corner as the j end of the next edge
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prev_x <= xi;
            r_prev_y <= yi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hit <= straddle;
        r_a_dx  <= xj_e - xi_e;
        r_a_dy  <= yj_e - yi_e;
        r_a_ax  <= px_e - xi_e;
        r_a_by  <= py_e - yi_e;
        r_b_hit    <= r_a_hit;
        r_b_dy_pos <= r_a_dy > DIFF_W'(0);
        r_b_lhs    <= PROD_W'(r_a_ax) * PROD_W'(r_a_dy);
        r_b_rhs    <= PROD_W'(r_a_dx) * PROD_W'(r_a_by);
    end

    assign left = r_b_dy_pos ? (r_b_lhs < r_b_rhs) : (r_b_rhs < r_b_lhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.vld && !i_ctl.first;
            r_b_vld <= r_a_vld;
            if (i_ctl.clr) begin
                r_parity <= 1'b0;
            end else if (r_b_vld && r_b_hit && left) begin
                r_parity <= !r_parity;
            end
        end
    end

    assign o_busy   = r_a_vld || r_b_vld;
    assign o_parity = r_parity;

endmodule

// ===== dv/point_in_polygon_checker.sv =====
// Checker for the point-in-polygon core: follows every transaction, predicts the inside flags and compares them.
module point_in_polygon_checker
    import pip_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_kind,
    input  logic [SLOT_W-1:0]         i_vertex_slot,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic signed [PT_IN_W-1:0] i_point_x,
    input  logic signed [PT_IN_W-1:0] i_point_y,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_inside_res,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                      flag;
        logic signed [PT_IN_W-1:0] px;
        logic signed [PT_IN_W-1:0] py;
        int                        corners;
        int                        serial;
    } t_inside_expect;

    logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
    logic [CFG_W-1:0]          poly_size = '0;
    t_inside_expect            inside_expected [$];
    int                        fails = 0;
    int                        queries_seen = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    // Even-odd rule with the crossing test done as an exact cross-multiplied compare
    function automatic logic point_is_inside(input logic signed [PT_IN_W-1:0] qx,
                                             input logic signed [PT_IN_W-1:0] qy);
        int     n;
        int     i;
        int     j;
        longint px, py, xi, yi, xj, yj, dx, dy, lhs, rhs;
        logic   parity;
        logic   left;
        n = (poly_size > MAX_VERTICES) ? MAX_VERTICES : int'(poly_size);
        px = longint'(qx) <<< FRAC_W;
        py = longint'(qy) <<< FRAC_W;
        parity = 1'b0;
        j = n - 1;
        for (i = 0; i < n; i++) begin
            xi = longint'(poly_x[i]);
            yi = longint'(poly_y[i]);
            xj = longint'(poly_x[j]);
            yj = longint'(poly_y[j]);
            if ((yi > py) != (yj > py)) begin
                dx = xj - xi;
                dy = yj - yi;
                lhs = (px - xi) * dy;
                rhs = dx * (py - yi);
                left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                if (left)
                    parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    always @(posedge i_clk) begin
        t_inside_expect exp_item;
        t_inside_expect got_for;
        if (!i_rst_n) begin
            poly_size = '0;
            inside_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (inside_expected.size() == 0) begin
                    report_mismatch($sformatf("inside flag %0b with no query outstanding",
                                              i_inside_res));
                end else begin
                    got_for = inside_expected.pop_front();
                    if (i_inside_res !== got_for.flag)
                        report_mismatch($sformatf(
                            "query %0d point (%0d,%0d) over %0d corners: inside %0b, want %0b",
                            got_for.serial, got_for.px, got_for.py, got_for.corners,
                            i_inside_res, got_for.flag));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                poly_size = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_LOAD) begin
                    poly_x[i_vertex_slot] = i_vertex_x;
                    poly_y[i_vertex_slot] = i_vertex_y;
                end else begin
                    exp_item.flag    = point_is_inside(i_point_x, i_point_y);
                    exp_item.px      = i_point_x;
                    exp_item.py      = i_point_y;
                    exp_item.corners = int'(poly_size);
                    exp_item.serial  = queries_seen;
                    queries_seen++;
                    inside_expected.push_back(exp_item);
                end
            end
        end
        o_fail_count = fails;
        o_pending    = inside_expected.size();
    end

endmodule

// ===== dv/tb_point_in_polygon_test_core.sv =====
// Testbench top for the point-in-polygon core: stimulus, handshake idling and the verdict.
module tb_point_in_polygon_test_core
    import pip_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_TOTAL     = 1550;
    localparam int PHASE_ITEMS     = 96;
    localparam int HOLD_OFF_CYCLES = 400;
    // long enough for a query over the full store to finish
    localparam int SETTLE_CYCLES   = MAX_VERTICES + 16;
    // longest quiet stretch of a correct run is the hold-off plus one full walk
    localparam int STALL_LIMIT     = 4000;
    localparam int BUSY_PCT        = 76;
    localparam int SHARED_PCT      = 32;
    localparam int ONE             = 1 << FRAC_W;
    localparam int COUNT_MAX       = (1 << CFG_W) - 1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_WINDOW,
        SHAPE_STEPS
    } t_shape;

    // Drive every input to a known value from time zero
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic [CFG_W-1:0]          i_cfg_data    = '0;
    logic                      i_in_valid    = 1'b0;
    logic                      i_kind        = KIND_LOAD;
    logic [SLOT_W-1:0]         i_vertex_slot = '0;
    logic signed [COORD_W-1:0] i_vertex_x    = '0;
    logic signed [COORD_W-1:0] i_vertex_y    = '0;
    logic signed [PT_IN_W-1:0] i_point_x     = '0;
    logic signed [PT_IN_W-1:0] i_point_y     = '0;
    logic                      i_out_ready   = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_inside_res;

    int     fail_count;
    int     pending;
    int     items_sent  = 0;
    int     holds_asked = 0;
    int     holds_done  = 0;
    t_idle  idle_mode   = IDLE_NONE;
    t_shape shape       = SHAPE_WIDE;
    int     win_cx      = 0;
    int     win_cy      = 0;
    int     win_span    = 16;

    always #1 i_clk = ~i_clk;

    point_in_polygon_test_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_vertex_slot (i_vertex_slot),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_inside_res  (o_inside_res)
    );

    point_in_polygon_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_vertex_slot (i_vertex_slot),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_inside_res  (o_inside_res),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < BUSY_PCT;
            IDLE_BOTH: return $urandom_range(99) < SHARED_PCT;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < BUSY_PCT;
            IDLE_BOTH: return $urandom_range(99) < SHARED_PCT;
            default:   return 1'b0;
        endcase
    endfunction

    // Uniform offset in [-span, span]
    function automatic int spread(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Q15.8 coordinate near a whole-number center, with a random fraction half the time
    function automatic int near_fixed(input int center, input int span);
        return (center + spread(span)) * ONE
               + ($urandom_range(1) ? int'($urandom_range(ONE - 1)) : 0);
    endfunction

    // Present one input transaction at a falling edge and hold it until it is taken
    task automatic send_item(input logic                      kind,
                             input logic [SLOT_W-1:0]         slot,
                             input logic signed [COORD_W-1:0] vx,
                             input logic signed [COORD_W-1:0] vy,
                             input logic signed [PT_IN_W-1:0] px,
                             input logic signed [PT_IN_W-1:0] py);
        @(negedge i_clk);
        if (sender_idles()) begin
            // drop valid for a random gap before the next transaction
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (sender_idles());
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_vertex_slot <= slot;
        i_vertex_x    <= vx;
        i_vertex_y    <= vy;
        i_point_x     <= px;
        i_point_y     <= py;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Load one corner; the point fields ride along with random content
    task automatic load_corner(input int slot, input int x, input int y);
        send_item(KIND_LOAD, SLOT_W'(slot), COORD_W'(x), COORD_W'(y),
                  PT_IN_W'($urandom), PT_IN_W'($urandom));
    endtask

    // Query one point; the corner fields ride along with random content
    task automatic test_point(input int x, input int y);
        send_item(KIND_QUERY, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  PT_IN_W'(x), PT_IN_W'(y));
    endtask

    // Lower valid, wait for every outstanding flag, then give the core time to go idle
    task automatic let_core_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write vertex_count while the core is idle
    task automatic write_vertex_count(input int value);
        let_core_settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Rewrite corners 0 .. corners-1 with a fresh polygon of a random style
    task automatic draw_polygon(input int corners);
        int k;
        int x;
        int y;
        shape  = t_shape'($urandom_range(SHAPE_STEPS));
        win_cx = int'($urandom_range(56000)) - 28000;
        win_cy = int'($urandom_range(56000)) - 28000;
        case ($urandom_range(3))
            0:       win_span = 4;
            1:       win_span = 16;
            2:       win_span = 256;
            default: win_span = 4096;
        endcase
        x = win_cx;
        y = win_cy;
        for (k = 0; k < corners; k++) begin
            case (shape)
                SHAPE_WIDE:   load_corner(k, $urandom, $urandom);
                SHAPE_WINDOW: load_corner(k, near_fixed(win_cx, win_span),
                                          near_fixed(win_cy, win_span));
                default: begin
                    // rectilinear walk on whole coordinates: every other edge is horizontal
                    if (k % 2 == 0)
                        x = win_cx + spread(win_span);
                    else
                        y = win_cy + spread(win_span);
                    load_corner(k, x * ONE, y * ONE);
                end
            endcase
        end
    endtask

    // Pick a query point that matches the polygon last drawn
    task automatic probe_polygon();
        if (shape == SHAPE_WIDE)
            test_point($urandom, $urandom);
        else
            test_point(win_cx + spread(win_span + 2), win_cy + spread(win_span + 2));
    endtask

    // Result side: accept at random, and serve requested long hold-offs in cycles of its own
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                // hold ready low so the core fills up and pushes back on its input
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                holds_done++;
            end else begin
                i_out_ready <= !receiver_stalls();
            end
        end
    end

    // Watchdog: end the run when no transaction of any kind moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int count;
        int used;
        int roll;
        int k;
        int phase_end;

        // Hold reset, then release it at a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed part ----
        // Empty polygon: any point, including the extreme corners of the grid, is outside
        write_vertex_count(0);
        test_point(-32768, 32767);
        test_point(32767, -32768);
        // Square of side 20 around the origin, plus extreme values in the top two slots
        load_corner(0, -10 * ONE, -10 * ONE);
        load_corner(1, 10 * ONE, -10 * ONE);
        load_corner(2, 10 * ONE, 10 * ONE);
        load_corner(3, -10 * ONE, 10 * ONE);
        load_corner(MAX_VERTICES - 1, -(1 << (COORD_W - 1)), (1 << (COORD_W - 1)) - 1);
        load_corner(MAX_VERTICES - 2, (1 << (COORD_W - 1)) - 1, -(1 << (COORD_W - 1)));

        // One corner: its edge is degenerate and never toggles
        write_vertex_count(1);
        test_point(-10, -10);

        // Two corners on a diagonal: both edges cross the row and cancel
        write_vertex_count(2);
        load_corner(1, 10 * ONE, 10 * ONE);
        test_point(-5, 0);
        load_corner(1, 10 * ONE, -10 * ONE);

        // Square: interior, edges, rows of the horizontal edges, far outside
        write_vertex_count(4);
        test_point(0, 0);
        test_point(-10, 0);
        test_point(10, 0);
        test_point(0, -10);
        test_point(0, 10);
        test_point(-32768, 0);
        test_point(32767, 32767);

        // Fill the whole store so every count setting reads written corners only
        for (k = 0; k < MAX_VERTICES; k++)
            load_corner(k, $urandom, $urandom);

        // ---- Random part: phases of count setting, idling style and polygon traffic ----
        for (phase = 0; items_sent < ITEMS_TOTAL; phase++) begin
            case (phase % 8)
                0:       count = $urandom_range(8, 3);
                1:       count = MAX_VERTICES;
                2:       count = $urandom_range(16, 3);
                3:       count = COUNT_MAX;
                4:       count = $urandom_range(2, 1);
                5:       count = $urandom_range(COUNT_MAX - 1, MAX_VERTICES + 1);
                6:       count = $urandom_range(MAX_VERTICES - 1, 9);
                default: count = 0;
            endcase
            write_vertex_count(count);
            idle_mode = t_idle'((phase + phase / 8) % 4);
            if (phase % 7 == 2)
                holds_asked++;
            used = (count > MAX_VERTICES) ? MAX_VERTICES : count;
            if (used > 0)
                draw_polygon(used);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                roll = $urandom_range(99);
                if (roll < 12 && used > 0)
                    draw_polygon(used);
                else if (roll < 88)
                    repeat ($urandom_range(6, 1)) probe_polygon();
                else if (roll < 94)
                    load_corner($urandom_range(MAX_VERTICES - 1), $urandom, $urandom);
                else
                    test_point($urandom, $urandom);
            end
        end

        // Drain every outstanding flag, then give the verdict
        idle_mode = IDLE_NONE;
        let_core_settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
